@@ rtl/vcct_pkg.sv @@
// Package for the vertical capsule collision test: word types, side-band
// record and fixed-point constants. No dependencies.
`timescale 1ns / 1ps
package vcct_pkg;

    localparam int NORM_ONE   = 16384;  // 1.0 in Q2.14
    localparam int DIST_EPS   = 65;     // 0.001 in Q16.16
    localparam int ROUND_HALF = 8192;   // 0.5 in Q2.14, the rounding half
    localparam int SQRT_BITS  = 32;     // root bits of a 64-bit square
    localparam int DIV_BITS   = 15;     // quotient bits of the normal divide
    localparam int NUM_W      = 47;     // normal dividend width

    typedef struct packed {
        logic [31:0] a_base_x;
        logic [31:0] a_base_y;
        logic [31:0] a_base_z;
        logic [30:0] a_height;
        logic [30:0] a_radius;
        logic [31:0] b_base_x;
        logic [31:0] b_base_y;
        logic [31:0] b_base_z;
        logic [30:0] b_height;
        logic [30:0] b_radius;
        logic [31:0] other_id;
    } t_in_word;

    typedef struct packed {
        logic        hit;
        logic [31:0] report_id;
        logic [31:0] contact_x;
        logic [31:0] contact_y;
        logic [31:0] contact_z;
        logic [15:0] normal_x;
        logic [15:0] normal_y;
        logic [15:0] normal_z;
        logic [30:0] penetration;
    } t_out_word;

    // Values carried alongside the pipeline
    typedef struct packed {
        logic        hit;
        logic [31:0] id;
        logic [31:0] bx;
        logic [31:0] bz;
        logic [31:0] cy;   // saturated contact y
        logic [30:0] br;
        logic [31:0] sr;   // summed radii
        logic        sx;   // sign of dx
        logic        sz;   // sign of dz
        logic [31:0] adx;  // |dx|
        logic [31:0] adz;  // |dz|
    } t_side;

endpackage

@@ rtl/vcct_front.sv @@
// Front stages: axis offsets, vertical span test, squares and the radius test.
// Depends on vcct_pkg.
`timescale 1ns / 1ps
module vcct_front import vcct_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_in_word    i_word,
    output logic        o_valid,
    output logic [63:0] o_dsq,
    output t_side       o_side
);

    logic [32:0] dx, dz;
    logic [33:0] a_top, b_top, a_y, b_y;
    logic [32:0] cy_sum;
    logic        vert_ok;
    t_side       n1_side;
    t_side       n3_side;

    logic        r1_valid, r2_valid, r3_valid;
    t_side       r1_side, r2_side, r3_side;
    logic [63:0] r2_dx2, r2_dz2, r2_sr2, r3_dsq;
    logic [63:0] n2_dx2, n2_dz2, n2_sr2;
    logic [64:0] dsq_sum;

    // Form offsets, span test and contact height
    always_comb begin
        dx = {i_word.a_base_x[31], i_word.a_base_x} - {i_word.b_base_x[31], i_word.b_base_x};
        dz = {i_word.a_base_z[31], i_word.a_base_z} - {i_word.b_base_z[31], i_word.b_base_z};
        a_y   = {{2{i_word.a_base_y[31]}}, i_word.a_base_y};
        b_y   = {{2{i_word.b_base_y[31]}}, i_word.b_base_y};
        a_top = a_y + {3'b000, i_word.a_height};
        b_top = b_y + {3'b000, i_word.b_height};
        vert_ok = !($signed(a_top) < $signed(b_y)) && !($signed(b_top) < $signed(a_y));
        cy_sum = {i_word.b_base_y[31], i_word.b_base_y} + {3'b000, i_word.b_height[30:1]};

        n1_side.hit = vert_ok;
        n1_side.id  = i_word.other_id;
        n1_side.bx  = i_word.b_base_x;
        n1_side.bz  = i_word.b_base_z;
        n1_side.cy  = (cy_sum[32] != cy_sum[31]) ? 32'h7fff_ffff : cy_sum[31:0];
        n1_side.br  = i_word.b_radius;
        n1_side.sr  = {1'b0, i_word.a_radius} + {1'b0, i_word.b_radius};
        n1_side.sx  = dx[32];
        n1_side.sz  = dz[32];
        n1_side.adx = dx[32] ? 32'(-dx) : dx[31:0];
        n1_side.adz = dz[32] ? 32'(-dz) : dz[31:0];
    end

    // Square the offsets and the summed radii
    assign n2_dx2  = r1_side.adx * r1_side.adx;
    assign n2_dz2  = r1_side.adz * r1_side.adz;
    assign n2_sr2  = r1_side.sr * r1_side.sr;
    assign dsq_sum = {1'b0, r2_dx2} + {1'b0, r2_dz2};

    // Fold the radius test into the hit flag
    always_comb begin
        n3_side     = r2_side;
        n3_side.hit = r2_side.hit && !dsq_sum[64] && (dsq_sum[63:0] < r2_sr2);
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side <= n1_side;
            r2_side <= r1_side;
            r2_dx2  <= n2_dx2;
            r2_dz2  <= n2_dz2;
            r2_sr2  <= n2_sr2;
            r3_side <= n3_side;
            r3_dsq  <= dsq_sum[63:0];
        end
    end

    assign o_valid = r3_valid;
    assign o_dsq   = r3_dsq;
    assign o_side  = r3_side;

endmodule

@@ rtl/vcct_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
// Depends on vcct_pkg.
`timescale 1ns / 1ps
module vcct_sqrt import vcct_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [63:0] i_dsq,
    input  t_side       i_side,
    output logic        o_valid,
    output logic [31:0] o_dist,
    output t_side       o_side
);

    logic [SQRT_BITS-1:0] r_valid;
    logic [63:0]          r_v    [SQRT_BITS];
    logic [32:0]          r_rem  [SQRT_BITS];
    logic [31:0]          r_root [SQRT_BITS];
    t_side                r_side [SQRT_BITS];

    for (genvar k = 0; k < SQRT_BITS; k++) begin : g_stage
        logic [63:0] v_in;
        logic [32:0] rem_in;
        logic [31:0] root_in;
        t_side       side_in;
        logic        vld_in;
        logic [34:0] rem_sh, trial;
        logic        ge;

        if (k == 0) begin : g_first
            assign v_in    = i_dsq;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign side_in = r_side[k-1];
            assign vld_in  = r_valid[k-1];
        end

        // Bring down two bits and try the next root bit
        assign rem_sh = {rem_in, v_in[63-2*k -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[k]    <= v_in;
                r_rem[k]  <= ge ? 33'(rem_sh - trial) : rem_sh[32:0];
                r_root[k] <= {root_in[30:0], ge};
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_valid[SQRT_BITS-1];
    assign o_dist  = r_root[SQRT_BITS-1];
    assign o_side  = r_side[SQRT_BITS-1];

endmodule

@@ rtl/vcct_div.sv @@
// Penetration and pipelined rounding divide of the offsets by the distance.
// Depends on vcct_pkg.
`timescale 1ns / 1ps
module vcct_div import vcct_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [31:0]         i_dist,
    input  t_side               i_side,
    output logic                o_valid,
    output logic [DIV_BITS-1:0] o_qx,
    output logic [DIV_BITS-1:0] o_qz,
    output logic [31:0]         o_pen,
    output logic                o_small,
    output t_side               o_side
);

    localparam int NSTG = DIV_BITS + 1;

    logic [NSTG-1:0]     r_valid;
    logic [31:0]         r_dist  [NSTG];
    logic [NUM_W-1:0]    r_remx  [NSTG];
    logic [NUM_W-1:0]    r_remz  [NSTG];
    logic [DIV_BITS-1:0] r_qx    [NSTG];
    logic [DIV_BITS-1:0] r_qz    [NSTG];
    logic [31:0]         r_pen   [NSTG];
    logic                r_small [NSTG];
    t_side               r_side  [NSTG];

    // Load dividends with the rounding half, form penetration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dist[0]  <= i_dist;
            r_remx[0]  <= {1'b0, i_side.adx, 14'd0} + {16'd0, i_dist[31:1]};
            r_remz[0]  <= {1'b0, i_side.adz, 14'd0} + {16'd0, i_dist[31:1]};
            r_qx[0]    <= '0;
            r_qz[0]    <= '0;
            r_pen[0]   <= i_side.sr - i_dist;
            r_small[0] <= (i_dist <= 32'(DIST_EPS));
            r_side[0]  <= i_side;
        end
    end

    // Restoring divide, one quotient bit per stage, top bit first
    for (genvar j = 1; j < NSTG; j++) begin : g_stage
        localparam int SH = DIV_BITS - j;
        logic [NUM_W-1:0] dsh;
        logic             gex, gez;

        assign dsh = {{(NUM_W-32){1'b0}}, r_dist[j-1]} << SH;
        assign gex = (r_remx[j-1] >= dsh);
        assign gez = (r_remz[j-1] >= dsh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_valid[j] <= r_valid[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dist[j]      <= r_dist[j-1];
                r_remx[j]      <= gex ? r_remx[j-1] - dsh : r_remx[j-1];
                r_remz[j]      <= gez ? r_remz[j-1] - dsh : r_remz[j-1];
                r_qx[j]        <= r_qx[j-1] | (DIV_BITS'(gex) << SH);
                r_qz[j]        <= r_qz[j-1] | (DIV_BITS'(gez) << SH);
                r_pen[j]       <= r_pen[j-1];
                r_small[j]     <= r_small[j-1];
                r_side[j]      <= r_side[j-1];
            end
        end
    end

    assign o_valid = r_valid[NSTG-1];
    assign o_qx    = r_qx[NSTG-1];
    assign o_qz    = r_qz[NSTG-1];
    assign o_pen   = r_pen[NSTG-1];
    assign o_small = r_small[NSTG-1];
    assign o_side  = r_side[NSTG-1];

endmodule

@@ rtl/vcct_back.sv @@
// Back stages: clamp the normal, scale by the contact offset, round, saturate.
// Depends on vcct_pkg.
`timescale 1ns / 1ps
module vcct_back import vcct_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [DIV_BITS-1:0] i_qx,
    input  logic [DIV_BITS-1:0] i_qz,
    input  logic [31:0]         i_pen,
    input  logic                i_small,
    input  t_side               i_side,
    output logic                o_valid,
    output t_out_word           o_word
);

    logic                r1_valid, r2_valid, r3_valid;
    t_side               r1_side, r2_side;
    logic [DIV_BITS-1:0] r1_mx, r1_mz, r2_mx, r2_mz;
    logic                r1_nsx, r1_nsz, r2_nsx, r2_nsz;
    logic [31:0]         r1_s;
    logic [30:0]         r1_pen, r2_pen;
    logic [46:0]         r2_px, r2_pz;
    t_out_word           r3_word;
    t_out_word           n3_word;
    logic [DIV_BITS-1:0] n1_mx, n1_mz;
    logic [47:0]         rx, rz;
    logic [31:0]         cx, cz;

    function automatic logic [DIV_BITS-1:0] clamp_one(input logic [DIV_BITS-1:0] q);
        return (q > DIV_BITS'(NORM_ONE)) ? DIV_BITS'(NORM_ONE) : q;
    endfunction

    // Add the signed offset to the base and saturate to 32 bits
    function automatic logic [31:0] place(input logic [31:0] base, input logic neg,
                                          input logic [33:0] mag);
        logic [35:0] sum;
        sum = {{4{base[31]}}, base} + (neg ? 36'(-{2'b00, mag}) : {2'b00, mag});
        if ($signed(sum) > $signed(36'sh0_7fff_ffff)) begin
            return 32'h7fff_ffff;
        end else if ($signed(sum) < $signed(36'shf_8000_0000)) begin
            return 32'h8000_0000;
        end
        return sum[31:0];
    endfunction

    assign n1_mx = i_small ? '0 : clamp_one(i_qx);
    assign n1_mz = i_small ? DIV_BITS'(NORM_ONE) : clamp_one(i_qz);
    assign rx = {1'b0, r2_px} + 48'(ROUND_HALF);
    assign rz = {1'b0, r2_pz} + 48'(ROUND_HALF);
    assign cx = place(r2_side.bx, r2_nsx, rx[47:14]);
    assign cz = place(r2_side.bz, r2_nsz, rz[47:14]);

    // Build the result word, all zero on a miss
    always_comb begin
        n3_word = '0;
        if (r2_side.hit) begin
            n3_word.hit         = 1'b1;
            n3_word.report_id   = r2_side.id;
            n3_word.contact_x   = cx;
            n3_word.contact_y   = r2_side.cy;
            n3_word.contact_z   = cz;
            n3_word.normal_x    = r2_nsx ? 16'(-{1'b0, r2_mx}) : {1'b0, r2_mx};
            n3_word.normal_z    = r2_nsz ? 16'(-{1'b0, r2_mz}) : {1'b0, r2_mz};
            n3_word.penetration = r2_pen;
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side <= i_side;
            r1_mx   <= n1_mx;
            r1_mz   <= n1_mz;
            r1_nsx  <= !i_small && i_side.sx;
            r1_nsz  <= !i_small && i_side.sz;
            r1_s    <= {1'b0, i_side.br} + {1'b0, i_pen[31:1]};
            r1_pen  <= i_pen[31] ? 31'h7fff_ffff : i_pen[30:0];

            r2_side <= r1_side;
            r2_mx   <= r1_mx;
            r2_mz   <= r1_mz;
            r2_nsx  <= r1_nsx;
            r2_nsz  <= r1_nsz;
            r2_pen  <= r1_pen;
            r2_px   <= r1_mx * r1_s;
            r2_pz   <= r1_mz * r1_s;

            r3_word <= n3_word;
        end
    end

    assign o_valid = r3_valid;
    assign o_word  = r3_word;

endmodule

@@ rtl/vertical_capsule_collision_test.sv @@
// Top level of the vertical capsule collision test: pipeline and output skid.
// Depends on vcct_pkg, vcct_front, vcct_sqrt, vcct_div and vcct_back.
//
// Usage: present a capsule pair as one word on i_word with i_valid high; it is
// taken at a rising edge where o_stall is low. One result word per input word
// comes out on o_word with o_valid high, taken where i_stall is low, in order.
// Throughput: one pair per cycle while o_stall is low. From acceptance a word
// passes 3 front stages, 32 square-root stages of one root bit each, 16 divide
// stages for the normal, 3 back stages and the output register.
// The square-root and divide chains set the depth.
// A stalled output is held; one more word lands in a skid register, and the
// whole pipeline then freezes (o_stall high) until the skid drains. o_stall is
// a register output. Synchronous active-low reset clears all valid bits; no
// clearing pass is needed. A miss returns an all-zero word, hit included.
`timescale 1ns / 1ps
module vertical_capsule_collision_test import vcct_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);

    logic                en;
    logic                f_valid, s_valid, d_valid, b_valid;
    logic [63:0]         f_dsq;
    t_side               f_side, s_side, d_side;
    logic [31:0]         s_dist, d_pen;
    logic [DIV_BITS-1:0] d_qx, d_qz;
    logic                d_small;
    t_out_word           b_word;

    logic                r_out_valid, r_skid_valid, n_out_valid, n_skid_valid;
    t_out_word           r_out_word, r_skid_word, n_out_word, n_skid_word;

    assign en = !r_skid_valid;

    vcct_front u_front (
        .i_clk, .i_rst_n, .i_en(en), .i_valid, .i_word,
        .o_valid(f_valid), .o_dsq(f_dsq), .o_side(f_side)
    );

    vcct_sqrt u_sqrt (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(f_valid), .i_dsq(f_dsq), .i_side(f_side),
        .o_valid(s_valid), .o_dist(s_dist), .o_side(s_side)
    );

    vcct_div u_div (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(s_valid), .i_dist(s_dist), .i_side(s_side),
        .o_valid(d_valid), .o_qx(d_qx), .o_qz(d_qz), .o_pen(d_pen), .o_small(d_small),
        .o_side(d_side)
    );

    vcct_back u_back (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(d_valid), .i_qx(d_qx), .i_qz(d_qz),
        .i_pen(d_pen), .i_small(d_small), .i_side(d_side),
        .o_valid(b_valid), .o_word(b_word)
    );

    // Route the pipeline word to the output register or the skid
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_word   = r_out_word;
        n_skid_valid = r_skid_valid;
        n_skid_word  = r_skid_word;
        if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_word   = r_skid_word;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = b_valid;
                n_out_word  = b_word;
            end
        end else if (b_valid && en) begin
            n_skid_valid = 1'b1;
            n_skid_word  = b_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word  <= n_out_word;
        r_skid_word <= n_skid_word;
    end

    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;

    // The skid holds a word only behind a held output word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word without output word");

    // The skid fills only from a stalled output
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall))
        else $error("skid filled while output was free");

    // A miss reports nothing
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_word.hit) |-> (o_word.report_id == 32'd0 &&
                                      o_word.penetration == 31'd0 &&
                                      o_word.normal_z == 16'd0))
        else $error("miss word carries contact data");

    // A hit always has a horizontal normal plane and nonzero depth
    a_hit_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.hit) |-> (o_word.normal_y == 16'd0 &&
                                     o_word.penetration != 31'd0))
        else $error("hit word malformed");

endmodule
